// File: hw/rtl/brsb_pkg.sv
package brsb_pkg;

  // Field and register widths.
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SR_W       = 18;
  localparam int unsigned TEMPO_W    = 10;
  localparam int unsigned BDIV_W     = 7;
  localparam int unsigned RPT_W      = 8;
  localparam int unsigned RL_W       = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Slice length numerator (sample_rate * 60) and denominator (tempo * division).
  localparam int unsigned NUM_W = 24;
  localparam int unsigned DEN_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAT_DIVISION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT  = 2'd3;

  // Register reset values.
  localparam logic [SR_W-1:0]    SAMPLE_RATE_RST   = 18'd48000;
  localparam logic [TEMPO_W-1:0] TEMPO_BPM_RST     = 10'd130;
  localparam logic [BDIV_W-1:0]  BEAT_DIVISION_RST = 7'd4;
  localparam logic [RPT_W-1:0]   REPEAT_COUNT_RST  = 8'd4;
  localparam logic [RL_W-1:0]    REPEATS_LEFT_RST  = 9'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_ACCESS,
    S_MOD,
    S_DELIVER
  } state_e;

  typedef enum logic [1:0] {
    RES_PASS,
    RES_PLAY,
    RES_ERR
  } res_sel_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/brsb_ram.sv
module brsb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hw/rtl/brsb_divider.sv
module brsb_divider #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NumW-1:0]           dividend_i,
  input  logic [DenW-1:0]           divisor_i,
  output brsb_pkg::div_status_t     status_o,
  output logic [NumW-1:0]           quotient_o,
  output logic [DenW-1:0]           remainder_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] dvs_q, dvs_d;

  logic [DenW:0]   rem_sh;
  logic [DenW+1:0] diff;
  logic            ge;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    rem_sh = {rem_q, quo_q[NumW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = ~diff[DenW+1];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NumW-2:0], ge};
      rem_d = ge ? diff[DenW-1:0] : rem_sh[DenW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

// File: hw/rtl/beat_repeat_sample_buffer.sv
// Beat-repeat stutter buffer: every input beat carries one Q1.23 sample and a trigger flag in
// tuser, and yields exactly one output beat. A beat passes through accept, memory access and
// delivery; the sample memory is written and read in the access state.
// When the slice length has been shortened mid run so that the play position lies beyond the new
// end, the wrap is found by the shared 24-step divider before delivery. After reset and after
// every configuration write the slice length is recomputed by the same divider, which holds
// s_axis_tready low while it runs. The sample memory is not cleared after reset; playback only
// reads entries recorded since the last trigger. Once a beat has been recorded with an invalid
// slice length, every later beat is zero with the error flag set until reset.
module beat_repeat_sample_buffer #(
  parameter int unsigned BUFFER_DEPTH = 131072
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [brsb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [brsb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [brsb_pkg::SAMPLE_W-1:0]       s_axis_tdata,  // [23:0] sample_in
  input  logic                                s_axis_tuser,  // [0] trigger
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [brsb_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [23:0] sample_out
  output logic                                m_axis_tuser   // [0] error_flag
);

  localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
  localparam int unsigned PW   = AW + 1;
  localparam int unsigned DVSW = (brsb_pkg::DEN_W > PW) ? brsb_pkg::DEN_W : PW;
  localparam logic [PW-1:0] DEPTH_L = PW'(BUFFER_DEPTH);

  brsb_pkg::state_e   state_q, state_d;
  brsb_pkg::res_sel_e res_sel_q, res_sel_d;

  logic [brsb_pkg::SR_W-1:0]    sr_q;
  logic [brsb_pkg::TEMPO_W-1:0] tempo_q;
  logic [brsb_pkg::BDIV_W-1:0]  bdiv_q;
  logic [brsb_pkg::RPT_W-1:0]   rpt_q;

  logic          calc_pend_q;
  logic          slice_ok_q;
  logic [PW-1:0] slice_val_q;
  logic [PW-1:0] slice_len_q, slice_len_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [AW-1:0] pp_q, pp_d;
  logic [brsb_pkg::RL_W-1:0] rl_q, rl_d;
  logic          playing_q, playing_d;
  logic          err_q, err_d;
  logic          trig_q;
  logic [brsb_pkg::SAMPLE_W-1:0] sample_q;
  logic          fwd_q;

  logic                          out_valid_q;
  logic [brsb_pkg::SAMPLE_W-1:0] out_data_q;
  logic                          out_err_q;

  // FSM control.
  logic in_acc, div_start, ram_we, ram_re, out_load, need_mod;

  // Access cycle datapath.
  logic [PW-1:0]             wp_eff;
  logic [AW-1:0]             pp_eff;
  logic [PW-1:0]             pp_n;
  logic [brsb_pkg::RL_W-1:0] rl_eff;
  logic                      do_write, do_play;

  // Divider.
  logic [brsb_pkg::NUM_W-1:0] div_num;
  logic [DVSW-1:0]            div_den;
  brsb_pkg::div_status_t      div_st;
  logic [brsb_pkg::NUM_W-1:0] div_quo;
  logic [DVSW-1:0]            div_rem;
  logic [brsb_pkg::DEN_W-1:0] den;
  logic [brsb_pkg::NUM_W-1:0] sr_x60;

  logic [brsb_pkg::SAMPLE_W-1:0] ram_rdata;

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // Slice length operands.
  assign den    = brsb_pkg::DEN_W'(tempo_q) * brsb_pkg::DEN_W'(bdiv_q);
  assign sr_x60 = (brsb_pkg::NUM_W'(sr_q) << 6) - (brsb_pkg::NUM_W'(sr_q) << 2);

  always_comb begin
    wp_eff   = trig_q ? '0 : wp_q;
    pp_eff   = trig_q ? '0 : pp_q;
    rl_eff   = trig_q ? (brsb_pkg::RL_W'(rpt_q) + 1'b1) : rl_q;
    do_write = wp_eff < DEPTH_L;
    do_play  = (trig_q | playing_q) & do_write & (rl_eff != '0);
    pp_n     = PW'(pp_eff) + 1'b1;

    slice_len_d = (do_write && slice_ok_q) ? slice_val_q : slice_len_q;
    err_d       = do_write & ~slice_ok_q;
    wp_d        = do_write ? wp_eff + 1'b1 : wp_eff;
    playing_d   = (trig_q | playing_q) & do_write;
    rl_d        = (do_play && pp_eff == '0) ? rl_eff - 1'b1 : rl_eff;
    need_mod    = do_play & (pp_n > slice_len_d);
    if (!do_play) begin
      pp_d = pp_eff;
    end else if (pp_n == slice_len_d) begin
      pp_d = '0;
    end else begin
      pp_d = pp_n[AW-1:0];
    end
    res_sel_d = do_play ? brsb_pkg::RES_PLAY : brsb_pkg::RES_PASS;
    if (err_q) begin
      res_sel_d = brsb_pkg::RES_ERR;
      need_mod  = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      brsb_pkg::S_IDLE: begin
        if (calc_pend_q) begin
          state_d = brsb_pkg::S_CALC;
        end else if (s_axis_tvalid) begin
          state_d = brsb_pkg::S_ACCESS;
        end
      end
      brsb_pkg::S_CALC: begin
        if (div_st.done) begin
          state_d = brsb_pkg::S_IDLE;
        end
      end
      brsb_pkg::S_ACCESS: begin
        state_d = need_mod ? brsb_pkg::S_MOD : brsb_pkg::S_DELIVER;
      end
      brsb_pkg::S_MOD: begin
        if (div_st.done) begin
          state_d = brsb_pkg::S_DELIVER;
        end
      end
      brsb_pkg::S_DELIVER: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = brsb_pkg::S_IDLE;
        end
      end
      default: state_d = brsb_pkg::S_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_num       = sr_x60;
    div_den       = DVSW'(den);
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      brsb_pkg::S_IDLE: begin
        s_axis_tready = ~calc_pend_q;
        div_start     = calc_pend_q;
      end
      brsb_pkg::S_ACCESS: begin
        ram_we    = ~err_q & do_write;
        ram_re    = ~err_q & do_play;
        div_start = need_mod;
        div_num   = brsb_pkg::NUM_W'(pp_n);
        div_den   = DVSW'(slice_len_d);
      end
      brsb_pkg::S_DELIVER: begin
        out_load = ~out_valid_q | m_axis_tready;
      end
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= brsb_pkg::SAMPLE_RATE_RST;
      tempo_q <= brsb_pkg::TEMPO_BPM_RST;
      bdiv_q  <= brsb_pkg::BEAT_DIVISION_RST;
      rpt_q   <= brsb_pkg::REPEAT_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        brsb_pkg::REG_SAMPLE_RATE:   sr_q    <= cfg_data_i[brsb_pkg::SR_W-1:0];
        brsb_pkg::REG_TEMPO_BPM:     tempo_q <= cfg_data_i[brsb_pkg::TEMPO_W-1:0];
        brsb_pkg::REG_BEAT_DIVISION: bdiv_q  <= cfg_data_i[brsb_pkg::BDIV_W-1:0];
        brsb_pkg::REG_REPEAT_COUNT:  rpt_q   <= cfg_data_i[brsb_pkg::RPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brsb_pkg::S_IDLE;
      calc_pend_q <= 1'b1;
      slice_ok_q  <= 1'b0;
      slice_len_q <= DEPTH_L;
      wp_q        <= '0;
      pp_q        <= '0;
      rl_q        <= brsb_pkg::REPEATS_LEFT_RST;
      playing_q   <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // A write during a running computation queues a fresh one.
      if (cfg_we_i) begin
        calc_pend_q <= 1'b1;
      end else if (div_start && state_q == brsb_pkg::S_IDLE) begin
        calc_pend_q <= 1'b0;
      end
      if (state_q == brsb_pkg::S_CALC && div_st.done) begin
        slice_ok_q <= (tempo_q != '0) && (bdiv_q != '0) && (div_quo != '0)
                      && (div_quo <= brsb_pkg::NUM_W'(BUFFER_DEPTH));
      end
      if (state_q == brsb_pkg::S_ACCESS && !err_q) begin
        slice_len_q <= slice_len_d;
        wp_q        <= wp_d;
        pp_q        <= pp_d;
        rl_q        <= rl_d;
        playing_q   <= playing_d;
        err_q       <= err_d;
      end
      if (state_q == brsb_pkg::S_MOD && div_st.done) begin
        pp_q <= div_rem[AW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == brsb_pkg::S_CALC && div_st.done) begin
      slice_val_q <= div_quo[PW-1:0];
    end
    if (in_acc) begin
      trig_q   <= s_axis_tuser;
      sample_q <= s_axis_tdata;
    end
    if (state_q == brsb_pkg::S_ACCESS) begin
      res_sel_q <= res_sel_d;
      // The entry played back is the one being recorded in the same beat.
      fwd_q     <= (wp_eff[AW-1:0] == pp_eff);
    end
    if (out_load) begin
      case (res_sel_q)
        brsb_pkg::RES_ERR: begin
          out_data_q <= '0;
          out_err_q  <= 1'b1;
        end
        brsb_pkg::RES_PLAY: begin
          out_data_q <= fwd_q ? sample_q : ram_rdata;
          out_err_q  <= 1'b0;
        end
        default: begin
          out_data_q <= sample_q;
          out_err_q  <= 1'b0;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  brsb_ram #(
    .Width (brsb_pkg::SAMPLE_W),
    .Depth (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_eff[AW-1:0]),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (pp_eff),
    .rdata_o (ram_rdata)
  );

  brsb_divider #(
    .NumW (brsb_pkg::NUM_W),
    .DenW (DVSW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .status_o    (div_st),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("latched error cleared without reset");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error beat carries a nonzero sample");

  a_div_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == brsb_pkg::S_CALC || state_q == brsb_pkg::S_MOD))
    else $error("divider running outside a state that waits for it");

  a_accept_access : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == brsb_pkg::S_ACCESS))
    else $error("accepted beat did not go to the memory access");

  a_wp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= DEPTH_L)
    else $error("write position beyond buffer depth");

endmodule
